### src/sha1_stream_hasher_assert.svh
// ---------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Shared concurrent assertion forms. All are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication.
`define SHA1_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHA1_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sha1_pkg.sv
// ---------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared types, operation codes and hash constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1_pkg;

  typedef logic [7:0]       byte_t;
  typedef logic [31:0]      word_t;
  typedef logic [4:0][31:0] digest_t;

  // Operation codes of the input channel.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Initial chaining words, entry 0 is the first digest word.
  localparam digest_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  localparam byte_t      PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [2:0] WORD_LAST   = 3'd4;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic  push;       // shift one byte into the message window
    byte_t push_byte;
    logic  start;      // begin compressing the window (with the final push)
    logic  clear;      // return the chaining words to their initial values
  } core_ctl_t;

  typedef struct packed {
    logic busy;        // rounds or the chaining update are in progress
  } core_sts_t;

endpackage

### src/sha1_stream_if.sv
// ---------------------------------------------------------------------------
// SHA-1 stream hasher channels
// Valid/ready channels for message bytes and digest words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha1_in_if;
  import sha1_pkg::*;

  logic  valid;
  logic  ready;
  logic  op;
  byte_t data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha1_out_if;
  import sha1_pkg::*;

  logic       valid;
  logic       ready;
  word_t      digest_word;
  logic [2:0] word_index;
  logic       last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

### src/sha1_core.sv
// ---------------------------------------------------------------------------
// SHA-1 compression core
// Message window, one shared round datapath and the chaining words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::core_ctl_t ctl,
  output sha1_pkg::core_sts_t sts,
  output sha1_pkg::digest_t   digest
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_FOLD = 3'b100
  } core_state_t;

  core_state_t  state_r, state_nxt;
  logic [6:0]   round_r, round_nxt;
  digest_t      hw_r, hw_nxt;
  logic [511:0] win_r, win_nxt;   // word 15 (top) is the oldest word
  digest_t      rw_r, rw_nxt;     // round words a..e at entries 0..4

  word_t w_cur, w_new, f_val, k_val, t_val;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  always_comb begin
    w_cur = win_r[511:480];
    w_new = rotl(win_r[447:416] ^ win_r[255:224] ^ win_r[95:64] ^ win_r[511:480], 1);
    if (round_r inside {[7'd0:7'd19]}) begin
      f_val = (rw_r[1] & rw_r[2]) | (~rw_r[1] & rw_r[3]);
      k_val = K_R0;
    end else if (round_r inside {[7'd20:7'd39]}) begin
      f_val = rw_r[1] ^ rw_r[2] ^ rw_r[3];
      k_val = K_R1;
    end else if (round_r inside {[7'd40:7'd59]}) begin
      f_val = (rw_r[1] & rw_r[2]) | (rw_r[1] & rw_r[3]) | (rw_r[2] & rw_r[3]);
      k_val = K_R2;
    end else begin
      f_val = rw_r[1] ^ rw_r[2] ^ rw_r[3];
      k_val = K_R3;
    end
    t_val = rotl(rw_r[0], 5) + f_val + rw_r[4] + w_cur + k_val;
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    hw_nxt    = hw_r;
    win_nxt   = win_r;
    rw_nxt    = rw_r;
    if (ctl.push) begin
      win_nxt = {win_r[503:0], ctl.push_byte};
    end
    case (state_r)
      C_IDLE: begin
        if (ctl.start) begin
          rw_nxt    = hw_r;
          round_nxt = '0;
          state_nxt = C_RUN;
        end
        if (ctl.clear) begin
          hw_nxt = H_INIT;
        end
      end
      C_RUN: begin
        // The window always advances; the word shifted in is the one needed
        // once it has reached the top of the window.
        win_nxt   = {win_r[479:0], w_new};
        rw_nxt    = {rw_r[3], rw_r[2], rotl(rw_r[1], 30), rw_r[0], t_val};
        round_nxt = round_r + 7'd1;
        if (round_r == ROUND_LAST) begin
          round_nxt = '0;
          state_nxt = C_FOLD;
        end
      end
      C_FOLD: begin
        for (int i = 0; i < 5; i++) begin
          hw_nxt[i] = hw_r[i] + rw_r[i];
        end
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      round_r <= '0;
      hw_r    <= H_INIT;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      hw_r    <= hw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    rw_r  <= rw_nxt;
  end

  assign sts.busy = (state_r != C_IDLE);
  assign digest   = hw_r;

endmodule

### src/sha1_stream_hasher.sv
// Absorb: a byte is taken while the sequencer is idle; the byte that completes a block
//   adds a compression (the rounds, one chaining update, the return to idle) first.
// Finish: 9 to 72 padding bytes at one byte per cycle between compressions, one or two
//   compressions, then five output transactions from the digest register.
// No byte is taken while the round datapath compresses a block, so it sets the sustained absorb rate.
// Reset (rst_n low, synchronous) restores the initial chaining words and empties the block.
// ---------------------------------------------------------------------------
// SHA-1 stream hasher top level
// Byte-stream SHA-1 with padding sequencer and digest output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha1_stream_hasher_assert.svh"

module sha1_stream_hasher (
  input  logic              clk,
  input  logic              rst_n,
  sha1_in_if.sink           in_ch,
  sha1_out_if.source        out_ch
);
  import sha1_pkg::*;

  // Top-level sequencer. IDLE is the only state that takes input; a byte
  // that fills the block sends it to COMP, and a finish walks PAD, COMP and
  // EMIT before coming back.
  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_PAD  = 4'b0010,
    T_COMP = 4'b0100,
    T_EMIT = 4'b1000
  } top_state_t;

  top_state_t  state_r, state_nxt;
  top_state_t  ret_r, ret_nxt;       // where to go once compression ends
  logic [5:0]  fill_r, fill_nxt;     // bytes pending in the current block
  logic [60:0] total_r, total_nxt;   // message bytes absorbed, wraps
  logic        first_r, first_nxt;   // next pad byte is the 0x80 marker
  logic        lenph_r, lenph_nxt;   // length bytes are being pushed
  logic [2:0]  lcnt_r, lcnt_nxt;     // next length byte, 0 is the top byte
  logic [2:0]  idx_r, idx_nxt;       // digest word on the output
  logic        ovld_r, ovld_nxt;
  word_t       oword_r, oword_nxt;

  core_ctl_t core_ctl;
  core_sts_t core_sts;
  digest_t   digest;

  logic        in_accept, out_accept, len_mode;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  byte_t       pad_byte;

  sha1_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (core_ctl),
    .sts    (core_sts),
    .digest (digest)
  );

  assign in_ch.ready = (state_r == T_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_accept  = out_ch.valid && out_ch.ready;

  // Padding byte stream: the marker, zeros up to offset 56, then the bit
  // length most significant byte first. Once the first length byte has gone
  // out the fill count moves past 56, so the length phase is remembered.
  assign bit_len  = {total_r, 3'b000};
  assign len_sel  = 3'd7 - lcnt_r;
  assign len_mode = !first_r && (lenph_r || (fill_r == LEN_OFFSET));

  always_comb begin
    if (first_r) begin
      pad_byte = PAD_BYTE;
    end else if (len_mode) begin
      pad_byte = bit_len[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    first_nxt = first_r;
    lenph_nxt = lenph_r;
    lcnt_nxt  = lcnt_r;
    idx_nxt   = idx_r;
    ovld_nxt  = ovld_r;
    oword_nxt = oword_r;
    core_ctl  = '0;

    case (state_r)
      T_IDLE: begin
        if (in_accept) begin
          if (in_ch.op == OP_ABSORB) begin
            core_ctl.push      = 1'b1;
            core_ctl.push_byte = in_ch.data_byte;
            fill_nxt           = fill_r + 6'd1;
            total_nxt          = total_r + 61'd1;
            if (fill_r == FILL_LAST) begin
              core_ctl.start = 1'b1;
              ret_nxt        = T_IDLE;
              state_nxt      = T_COMP;
            end
          end else begin
            first_nxt = 1'b1;
            lenph_nxt = 1'b0;
            lcnt_nxt  = '0;
            state_nxt = T_PAD;
          end
        end
      end
      T_PAD: begin
        core_ctl.push      = 1'b1;
        core_ctl.push_byte = pad_byte;
        fill_nxt           = fill_r + 6'd1;
        first_nxt          = 1'b0;
        if (len_mode) begin
          lenph_nxt = 1'b1;
          lcnt_nxt  = lcnt_r + 3'd1;
        end
        if (fill_r == FILL_LAST) begin
          // The last length byte always lands at the end of a block.
          core_ctl.start = 1'b1;
          ret_nxt        = (len_mode && (lcnt_r == 3'd7)) ? T_EMIT : T_PAD;
          state_nxt      = T_COMP;
        end
      end
      T_COMP: begin
        if (!core_sts.busy) begin
          state_nxt = ret_r;
          if (ret_r == T_EMIT) begin
            ovld_nxt  = 1'b1;
            idx_nxt   = '0;
            oword_nxt = digest[0];
          end
        end
      end
      T_EMIT: begin
        if (out_accept) begin
          if (idx_r == WORD_LAST) begin
            // Digest delivered: start a fresh message.
            ovld_nxt       = 1'b0;
            core_ctl.clear = 1'b1;
            fill_nxt       = '0;
            total_nxt      = '0;
            state_nxt      = T_IDLE;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            oword_nxt = digest[idx_r + 3'd1];
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      ret_r   <= T_IDLE;
      fill_r  <= '0;
      total_r <= '0;
      first_r <= 1'b0;
      lenph_r <= 1'b0;
      lcnt_r  <= '0;
      idx_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      first_r <= first_nxt;
      lenph_r <= lenph_nxt;
      lcnt_r  <= lcnt_nxt;
      idx_r   <= idx_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oword_r <= oword_nxt;
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.digest_word = oword_r;
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == WORD_LAST);

  // A new byte is never taken while the core still works on a block.
  `SHA1_ASSERT_IMP(a_no_input_busy, clk, rst_n, in_accept, !core_sts.busy,
                   "input transaction accepted while compression is running")
  // The digest is shown only after the final chaining update.
  `SHA1_ASSERT_IMP(a_out_stable, clk, rst_n, out_ch.valid,
                   !core_sts.busy && (state_r == T_EMIT),
                   "digest word presented outside the emit phase")
  // Compression starts only with the byte that completes a block.
  `SHA1_ASSERT_IMP(a_start_full, clk, rst_n, core_ctl.start, fill_r == FILL_LAST,
                   "compression started on a partial block")
  // After the final digest transaction the block is empty and idle.
  `SHA1_ASSERT_NXT(a_fresh_msg, clk, rst_n, out_accept && out_ch.last_word,
                   (state_r == T_IDLE) && (fill_r == 6'd0) && (total_r == 61'd0),
                   "block state not cleared after the last digest word")

endmodule

### tb/sv/sha1_digest_checker.sv
// ---------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both channels, hashes every accepted message byte on its own and
// compares each digest word that leaves the block with the predicted one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  logic clk,
  input  logic rst_n,
  sha1_in_if   in_mon,
  sha1_out_if  out_mon,
  output int   mismatch_count,
  output int   words_pending,
  output int   words_checked
);
  import sha1_pkg::*;

  typedef struct {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_entry_t;

  digest_entry_t digest_q[$];

  // Shadow hash state.
  word_t       chain_h[5];
  byte_t       block_bytes[64];
  logic [5:0]  fill_level;
  logic [60:0] message_bytes;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_message();
    int i;
    for (i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
    fill_level    = '0;
    message_bytes = '0;
  endfunction

  function automatic void compress_block();
    word_t sched[16];
    word_t a, b, c, d, e, f, k, t;
    int    i;
    int    r;
    for (i = 0; i < 16; i++)
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                  block_bytes[4*i+3]};
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16)
        sched[r & 15] = rotl(sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^
                             sched[(r + 2) & 15] ^ sched[r & 15], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = rotl(a, 5) + f + e + sched[r & 15] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endfunction

  function automatic void absorb_byte(input byte_t v);
    block_bytes[fill_level] = v;
    fill_level = fill_level + 1'b1;
    if (fill_level == '0) compress_block();
  endfunction

  // Pads the pending message, queues its five digest words and starts over.
  function automatic void finish_message();
    logic [63:0]   bit_len;
    digest_entry_t entry;
    int            i;
    bit_len = {message_bytes, 3'b000};
    absorb_byte(PAD_BYTE);
    while (fill_level != LEN_OFFSET) absorb_byte(8'h00);
    for (i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
    for (i = 0; i < 5; i++) begin
      entry.word  = chain_h[i];
      entry.index = i[2:0];
      entry.last  = (i[2:0] == WORD_LAST);
      digest_q.push_back(entry);
    end
    restart_message();
  endfunction

  always @(posedge clk) begin : monitor
    digest_entry_t want;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
      mismatch_count = 0;
      words_checked  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_ABSORB) begin
          absorb_byte(in_mon.data_byte);
          message_bytes = message_bytes + 1'b1;
        end else begin
          finish_message();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        words_checked++;
        if (digest_q.size() == 0) begin
          $error("digest_word: none expected, actual %h", out_mon.digest_word);
          mismatch_count++;
        end else begin
          want = digest_q.pop_front();
          if (out_mon.digest_word !== want.word) begin
            $error("digest_word: expected %h, actual %h", want.word,
                   out_mon.digest_word);
            mismatch_count++;
          end
          if (out_mon.word_index !== want.index) begin
            $error("word_index: expected %0d, actual %0d", want.index,
                   out_mon.word_index);
            mismatch_count++;
          end
          if (out_mon.last_word !== want.last) begin
            $error("last_word: expected %0b, actual %0b", want.last,
                   out_mon.last_word);
            mismatch_count++;
          end
        end
      end
    end
    words_pending = digest_q.size();
  end

endmodule

### tb/sv/sha1_stream_hasher_tb.sv
// ---------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Feeds byte messages of assorted lengths with random stalls on both sides
// and lets the digest checker compare every digest word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_stream_hasher_tb;
  import sha1_pkg::*;

  // The slowest finish pads up to 72 bytes and runs two compressions, so
  // no correct run goes anywhere near this many cycles without a single
  // transaction on either channel.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 300;
  localparam int TARGET_ITEMS   = 460;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  int mismatch_count;
  int words_pending;
  int words_checked;

  int items_sent;
  int messages_sent;
  int idle_cycles;

  // Shared by both sides: when low, neither the sender nor the receiver
  // inserts gaps, which gives back-to-back stretches.
  logic stall_enable;

  always #5 clk = ~clk;

  sha1_stream_hasher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1_digest_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending),
    .words_checked  (words_checked)
  );

  // Watchdog: any cycle with a transaction on either channel rearms it.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles.", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: for every digest word it draws a number of cycles to hold
  // ready low, then keeps ready high until a word has been taken.
  initial begin : digest_sink
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      gap = stall_enable ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Sends one item. It is entered at a falling edge and returns at the
  // falling edge after the transaction, so valid only ever gets one
  // assignment per time step and stays high between back-to-back items.
  task automatic send_item(input logic op, input byte_t value);
    int gap;
    gap = stall_enable ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_finish();
    send_item(OP_FINISH, byte_t'($urandom_range(0, 255)));
    messages_sent++;
  endtask

  task automatic send_random_message(input int unsigned len);
    repeat (len) send_item(OP_ABSORB, byte_t'($urandom_range(0, 255)));
    send_finish();
  endtask

  // Holds the sender back until every queued digest word has left the block.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
  endtask

  // Picks message lengths: mostly short ones for many digests, the rest
  // clustered around the padding boundaries at 56 and 64 bytes and around
  // a two-block message.
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 6) return $urandom_range(0, 12);
    if (sel == 7) return $urandom_range(54, 57);
    if (sel == 8) return $urandom_range(62, 65);
    return $urandom_range(118, 121);
  endfunction

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_ABSORB;
    in_ch.data_byte = 8'h00;
    stall_enable    = 1'b1;
    items_sent      = 0;
    messages_sent   = 0;

    // Synchronous reset, released at a falling edge so that the first item
    // follows cleanly.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. The empty message comes first, straight out of reset.
    send_finish();

    // The classic three-byte message.
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_finish();

    // Extreme byte values, then a second finish right after the first to
    // show that the state was returned to its initial values.
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hFF);
    send_finish();
    send_finish();

    // Alternating bit patterns, sent with no gaps.
    stall_enable = 1'b0;
    send_item(OP_ABSORB, 8'h55);
    send_item(OP_ABSORB, 8'hAA);
    send_item(OP_ABSORB, 8'h0F);
    send_item(OP_ABSORB, 8'hF0);
    send_finish();
    stall_enable = 1'b1;

    // Let the block drain completely before the random part.
    wait_drained();

    // Random part: whole messages with random content. Every fifth one the
    // sender waits for the block to empty before the next message.
    while (items_sent < TARGET_ITEMS) begin
      stall_enable = ($urandom_range(0, 3) != 0);
      send_random_message(pick_length());
      if ((messages_sent % 5) == 0) wait_drained();
    end

    // Wind down: nothing new, wait for the last digest words and a tail.
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d items in %0d messages, from empty to two-block lengths,",
             items_sent, messages_sent);
    $display("with random stalls on both channels; %0d digest words compared.",
             words_checked);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
